@@ rtl/rvq_pkg.sv @@
// shared constants and types for the residual vector quantized matvec block
package rvq_pkg;
	localparam int MaxStages  = 3;
	localparam int CodeCount  = 4096;
	localparam int MaxGroup   = 8;
	localparam int MaxColumns = 4096;
	localparam int RowLimit   = 4096;

	typedef enum logic [1:0] {
		REQ_CB_WRITE  = 2'd0,
		REQ_ACT_WRITE = 2'd1,
		REQ_GROUP     = 2'd2,
		REQ_NONE      = 2'd3
	} req_type_t;

	localparam logic [1:0] REG_STAGE_COUNT    = 2'd0;
	localparam logic [1:0] REG_GROUP_SIZE     = 2'd1;
	localparam logic [1:0] REG_GROUPS_PER_ROW = 2'd2;
	localparam logic [1:0] REG_OUTPUT_SHIFT   = 2'd3;

	localparam int InWidth  = 104;
	localparam int OutWidth = 32;
endpackage

@@ rtl/rvq_dequant_matvec_top.sv @@
// top level: rvq dequantizing matrix-vector product with codebook and activation memories
// write beats are accepted only while idle; a weight group reads one codebook word per cycle
// (stages inside each element), then scales and accumulates in the MUL and ACC states;
// the last group of a row then rounds and saturates into the output register (ROUND, SAT),
// and that step waits only while the previous row result is still held there
// arst_n clears control, registers to reset values, accumulator and counter; memories are not cleared
module rvq_dequant_matvec_top #(
	parameter int MAX_STAGES  = rvq_pkg::MaxStages,
	parameter int CODE_COUNT  = rvq_pkg::CodeCount,
	parameter int MAX_GROUP   = rvq_pkg::MaxGroup,
	parameter int MAX_COLUMNS = rvq_pkg::MaxColumns
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	// stage[1:0], code[13:2], element[16:14], position[28:17], value[44:29],
	// code0[56:45], code1[68:57], code2[80:69], group_scale[96:81], zero pad
	input  logic [rvq_pkg::InWidth-1:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// y_value[31:0]
	output logic [rvq_pkg::OutWidth-1:0] m_tdata,
	// saturated
	output logic        m_tuser
);
	import rvq_pkg::*;

	localparam int CW  = $clog2(CODE_COUNT);
	localparam int GW  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int SW  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int AW  = $clog2(MAX_COLUMNS);
	localparam int EW  = $clog2(MAX_GROUP + 1);
	localparam int CBD = MAX_STAGES * CODE_COUNT * MAX_GROUP;
	localparam int CBW = $clog2(CBD);

	// config registers
	logic [1:0]  stage_count_q;
	logic [3:0]  group_size_q;
	logic [12:0] groups_per_row_q;
	logic [5:0]  output_shift_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q    <= 2'd1;
			group_size_q     <= 4'd8;
			groups_per_row_q <= 13'd512;
			output_shift_q   <= 6'd22;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_STAGE_COUNT:    stage_count_q    <= pwdata[1:0];
				REG_GROUP_SIZE:     group_size_q     <= pwdata[3:0];
				REG_GROUPS_PER_ROW: groups_per_row_q <= pwdata[12:0];
				REG_OUTPUT_SHIFT:   output_shift_q   <= pwdata[5:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[3:2])
			REG_STAGE_COUNT:    prdata = {30'd0, stage_count_q};
			REG_GROUP_SIZE:     prdata = {28'd0, group_size_q};
			REG_GROUPS_PER_ROW: prdata = {19'd0, groups_per_row_q};
			REG_OUTPUT_SHIFT:   prdata = {26'd0, output_shift_q};
			default:            prdata = '0;
		endcase
	end

	// input fields
	req_type_t req;
	logic [1:0]  f_stage;
	logic [11:0] f_code, f_pos, f_c0, f_c1, f_c2;
	logic [2:0]  f_elem;
	logic signed [15:0] f_value, f_scale;
	assign req     = req_type_t'(s_tuser);
	assign f_stage = s_tdata[1:0];
	assign f_code  = s_tdata[13:2];
	assign f_elem  = s_tdata[16:14];
	assign f_pos   = s_tdata[28:17];
	assign f_value = s_tdata[44:29];
	assign f_c0    = s_tdata[56:45];
	assign f_c1    = s_tdata[68:57];
	assign f_c2    = s_tdata[80:69];
	assign f_scale = s_tdata[96:81];

	// effective config
	logic [SW:0]  ns_eff;
	logic [EW-1:0] gs_eff;
	logic [12:0]  gpr_eff;
	always_comb begin
		ns_eff  = (32'(stage_count_q) > MAX_STAGES) ? (SW+1)'(MAX_STAGES)
			: (SW+1)'(stage_count_q);
		gs_eff  = (32'(group_size_q) > MAX_GROUP) ? EW'(MAX_GROUP) : EW'(group_size_q);
		gpr_eff = (groups_per_row_q == 13'd0) ? 13'd1
			: (groups_per_row_q > 13'(RowLimit)) ? 13'(RowLimit) : groups_per_row_q;
	end

	// memories
	logic signed [15:0] cb_mem [CBD];
	logic signed [15:0] act_mem [MAX_COLUMNS];
	logic [CBW-1:0] cb_waddr, cb_raddr;
	logic           cb_we;
	logic signed [15:0] cb_rdata;
	logic [AW-1:0]  act_waddr, act_raddr;
	logic           act_we;
	logic signed [15:0] act_rdata;

	typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_MUL, ST_ACC, ST_ROUND, ST_SAT} state_t;
	state_t state_q;

	logic [CW-1:0]   codes_q [MAX_STAGES];
	logic signed [15:0] scale_q;
	logic [EW-1:0]   elem_q;
	logic [SW:0]     stg_q;
	logic            rd_s1, last_s1;
	logic            first_s1;
	logic [11:0]     grp_q;
	logic [AW-1:0]   col_base_q;
	logic signed [17:0] wsum_q;
	logic signed [33:0] prod_q;
	logic signed [40:0] dot_q;
	logic signed [63:0] term_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] rnd_q;
	logic            out_v_q;
	logic [31:0]     out_y_q;
	logic            out_sat_q;
	logic            last_row_q;

	logic s_fire;
	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;

	// one memory read per cycle: iterate stages inside element
	assign cb_we     = s_fire && req == REQ_CB_WRITE && 32'(f_stage) < MAX_STAGES
		&& 32'(f_code) < CODE_COUNT && 32'(f_elem) < MAX_GROUP;
	assign cb_waddr  = CBW'((32'(f_stage) * CODE_COUNT + 32'(f_code)) * MAX_GROUP
		+ 32'(f_elem));
	assign act_we    = s_fire && req == REQ_ACT_WRITE;
	assign act_waddr = AW'(f_pos);
	always_comb begin
		cb_raddr  = CBW'((32'(stg_q) * CODE_COUNT + 32'(codes_q[SW'(stg_q)])) * MAX_GROUP
			+ 32'(elem_q));
		act_raddr = col_base_q + AW'(elem_q);
	end
	always_ff @(posedge clk) begin
		if (cb_we) cb_mem[cb_waddr] <= f_value;
		if (act_we) act_mem[act_waddr] <= f_value;
		cb_rdata  <= cb_mem[cb_raddr];
		act_rdata <= act_mem[act_raddr];
	end

	logic stg_last, elem_last;
	assign stg_last  = (stg_q + 1'b1 >= ns_eff);
	assign elem_last = (32'(elem_q) + 1 >= 32'(gs_eff));

	logic signed [17:0] wsum_next;
	assign wsum_next = (first_s1 ? 18'sd0 : wsum_q) + 18'(cb_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_s1     <= 1'b0;
			last_s1   <= 1'b0;
			first_s1  <= 1'b0;
			grp_q     <= '0;
			acc_q     <= '0;
			out_v_q   <= 1'b0;
			elem_q    <= '0;
			stg_q     <= '0;
			dot_q     <= '0;
			prod_q    <= '0;
			last_row_q <= 1'b0;
		end else begin
			// a new row result in ST_SAT reloads the register in the same cycle
			if (out_v_q && m_tready && state_q != ST_SAT) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					rd_s1 <= 1'b0;
					if (s_fire && req == REQ_GROUP) begin
						codes_q[0] <= CW'(f_c0);
						if (MAX_STAGES > 1) codes_q[1 % MAX_STAGES] <= CW'(f_c1);
						if (MAX_STAGES > 2) codes_q[2 % MAX_STAGES] <= CW'(f_c2);
						scale_q    <= f_scale;
						col_base_q <= AW'(32'(grp_q) * 32'(gs_eff));
						elem_q     <= '0;
						stg_q      <= '0;
						dot_q      <= '0;
						prod_q     <= '0;
						last_row_q <= (32'(grp_q) + 1 >= 32'(gpr_eff));
						state_q    <= (gs_eff == '0 || ns_eff == '0) ? ST_MUL : ST_RUN;
					end
				end
				ST_RUN: begin
					rd_s1    <= 1'b1;
					first_s1 <= (stg_q == '0);
					last_s1  <= stg_last;
					if (stg_last) begin
						stg_q <= '0;
						elem_q <= elem_q + 1'b1;
						if (elem_last) state_q <= ST_MUL;
					end else begin
						stg_q <= stg_q + 1'b1;
					end
				end
				ST_MUL: begin
					rd_s1 <= 1'b0;
					if (!rd_s1 && prod_q == '0 && !last_s1) begin
						term_q  <= 64'(dot_q) * 64'(scale_q);
						state_q <= ST_ACC;
					end
					last_s1 <= 1'b0;
				end
				ST_ACC: begin
					if (last_row_q) begin
						acc_q   <= '0;
						grp_q   <= '0;
						rnd_q   <= acc_q + term_q + ((output_shift_q == '0) ? 64'sd0
							: (64'sd1 <<< (output_shift_q - 1'b1)));
						state_q <= ST_ROUND;
					end else begin
						acc_q   <= acc_q + term_q;
						grp_q   <= grp_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_ROUND: begin
					rnd_q   <= rnd_q >>> output_shift_q;
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (!out_v_q || m_tready) begin
						out_sat_q <= (rnd_q > 64'sd2147483647) || (rnd_q < -64'sd2147483648);
						out_y_q   <= (rnd_q > 64'sd2147483647) ? 32'h7fffffff
							: (rnd_q < -64'sd2147483648) ? 32'h80000000 : rnd_q[31:0];
						out_v_q   <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// element pipeline: s1 read issued, s2 data valid
			if (rd_s1) begin
				wsum_q <= wsum_next;
			end
			if (rd_s1 && last_s1) begin
				prod_q <= 34'(wsum_next) * 34'(act_rdata);
				dot_q  <= dot_q + 41'(prod_q);
			end else if (prod_q != '0 && !rd_s1) begin
				dot_q  <= dot_q + 41'(prod_q);
				prod_q <= '0;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_y_q;
	assign m_tuser  = out_sat_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("accept while busy");
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_sat_q) |-> (out_y_q == 32'h7fffffff || out_y_q == 32'h80000000))
		else $error("saturation flag without clipped value");
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> (acc_q == '0 && grp_q == '0)) else $error("row state not cleared");
endmodule
